// File: src/pcq_pkg.sv
// Shared constants, types and helper functions of the pointer click event queue.
package pcq_pkg;

   // Ring geometry.
   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);

   // Field widths.
   localparam int COORD_W  = 16;
   localparam int BUTTON_W = 5;
   localparam int TIME_W   = 32;
   localparam int COUNT_W  = 16;

   // Coordinate value held by the latest state after reset.
   localparam logic signed [COORD_W-1:0] COORD_RESET = -16'sd32768;

   // Request codes carried in the mode field.
   localparam logic MODE_REPORT  = 1'b0;
   localparam logic MODE_CONSUME = 1'b1;

   // One queued click event.
   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic [BUTTON_W-1:0]       buttons;
      logic [TIME_W-1:0]         time_ms;
   } click_entry_type;

   localparam int ENTRY_W = $bits(click_entry_type);

   // Commands from the top level to the ring.
   typedef struct packed {
      logic push;
      logic pop;
   } ring_ctrl_type;

   // Occupancy of the ring.
   typedef struct packed {
      logic full;
      logic empty;
   } ring_status_type;

   // Ring index advance with wrap at the last entry.
   function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] result;
      if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = idx + 1'b1;
      end
      return result;
   endfunction

endpackage

// File: src/pcq_ifs.sv
// Valid/ready channel interfaces for the request and response sides.
interface pcq_req_if import pcq_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic [BUTTON_W-1:0]       buttons;
   logic [TIME_W-1:0]         time_ms;

   modport source (output valid, mode, pos_x, pos_y, buttons, time_ms, input ready);
   modport sink   (input valid, mode, pos_x, pos_y, buttons, time_ms, output ready);
endinterface

interface pcq_rsp_if import pcq_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      ready_res;
   logic                      from_queue;
   logic signed [COORD_W-1:0] out_x;
   logic signed [COORD_W-1:0] out_y;
   logic [BUTTON_W-1:0]       out_buttons;
   logic [TIME_W-1:0]         out_time_ms;
   logic                      click_dropped;

   modport source (output valid, ready_res, from_queue, out_x, out_y, out_buttons,
                   out_time_ms, click_dropped, input ready);
   modport sink   (input valid, ready_res, from_queue, out_x, out_y, out_buttons,
                   out_time_ms, click_dropped, output ready);
endinterface

// File: src/pcq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pcq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read; a read of the address being written returns the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/pcq_ring.sv
// Click event ring: indices, full flag, entry storage and head-of-ring forwarding.
module pcq_ring import pcq_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  ring_ctrl_type   ctrl,
   input  click_entry_type push_data,
   output ring_status_type status,
   output click_entry_type head
);

   logic [IDX_W-1:0] read_index_ff, read_index_in;
   logic [IDX_W-1:0] write_index_ff, write_index_in;
   logic             ring_full_ff, ring_full_in;
   logic             bypass_ff, bypass_in;
   click_entry_type  bypass_data_ff;
   logic [ENTRY_W-1:0] ram_rd_data;

   // Index and full flag updates; a push and a pop never fall in the same cycle.
   always_comb begin
      read_index_in  = read_index_ff;
      write_index_in = write_index_ff;
      ring_full_in   = ring_full_ff;
      if (ctrl.push) begin
         write_index_in = next_index(write_index_ff);
         ring_full_in   = (next_index(write_index_ff) == read_index_ff);
      end else if (ctrl.pop) begin
         read_index_in = next_index(read_index_ff);
         ring_full_in  = 1'b0;
      end
   end

   // A push into the entry that becomes the head is forwarded, as the RAM returns the old word.
   assign bypass_in = ctrl.push && (write_index_ff == read_index_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         read_index_ff  <= '0;
         write_index_ff <= '0;
         ring_full_ff   <= 1'b0;
         bypass_ff      <= 1'b0;
      end else begin
         read_index_ff  <= read_index_in;
         write_index_ff <= write_index_in;
         ring_full_ff   <= ring_full_in;
         bypass_ff      <= bypass_in;
      end
   end

   always_ff @(posedge clock) begin
      bypass_data_ff <= push_data;
   end

   // The RAM is always addressed at the next head, so the head entry is ready every cycle.
   pcq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ctrl.push),
      .wr_addr(write_index_ff),
      .wr_data(push_data),
      .rd_addr(read_index_in),
      .rd_data(ram_rd_data)
   );

   assign head         = bypass_ff ? bypass_data_ff : click_entry_type'(ram_rd_data);
   assign status.full  = ring_full_ff;
   assign status.empty = !ring_full_ff && (read_index_ff == write_index_ff);

endmodule

// File: src/pointer_click_event_queue.sv
// Pointer click event queue: latest pointer state plus a ring of button-change events.
// Each beat on the request channel is either a pointer report (mode 0) or a consume
// request (mode 1) and yields exactly one response beat. A report replaces the latest
// pointer state and counts as pending; if its buttons differ from the previous ones it is
// also queued as a click in a QUEUE_DEPTH-entry ring, or dropped and flagged when the ring
// is full. A consume returns the oldest queued click, else the latest state, or answers
// not-ready when nothing is pending. The block takes one request per cycle: each beat is
// handled in the cycle it is accepted, with one RAM write or a read from the head register,
// and the result lands in the response register. A request is held off only while the
// response register is full and not being taken.
module pointer_click_event_queue import pcq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   pcq_req_if.sink   req_bus,
   pcq_rsp_if.source rsp_bus
);

   // Latest pointer state and report counters.
   logic signed [COORD_W-1:0] latest_x_ff, latest_x_in;
   logic signed [COORD_W-1:0] latest_y_ff, latest_y_in;
   logic [BUTTON_W-1:0]       latest_buttons_ff, latest_buttons_in;
   logic [TIME_W-1:0]         latest_time_ff, latest_time_in;
   logic [COUNT_W-1:0]        produced_ff, produced_in;
   logic [COUNT_W-1:0]        consumed_ff, consumed_in;

   // Response register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      ready_res_ff, ready_res_in;
   logic                      from_queue_ff, from_queue_in;
   logic signed [COORD_W-1:0] out_x_ff, out_x_in;
   logic signed [COORD_W-1:0] out_y_ff, out_y_in;
   logic [BUTTON_W-1:0]       out_buttons_ff, out_buttons_in;
   logic [TIME_W-1:0]         out_time_ff, out_time_in;
   logic                      dropped_ff, dropped_in;

   logic            req_fire;
   logic            button_change;
   logic            pending;
   ring_ctrl_type   ring_ctrl;
   ring_status_type ring_status;
   click_entry_type push_data;
   click_entry_type head;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign button_change = (req_bus.buttons != latest_buttons_ff);
   assign pending       = ring_status.full || (produced_ff != consumed_ff);

   assign push_data.pos_x   = req_bus.pos_x;
   assign push_data.pos_y   = req_bus.pos_y;
   assign push_data.buttons = req_bus.buttons;
   assign push_data.time_ms = req_bus.time_ms;

   // Per-beat work: state updates, ring commands and the response word.
   always_comb begin
      latest_x_in       = latest_x_ff;
      latest_y_in       = latest_y_ff;
      latest_buttons_in = latest_buttons_ff;
      latest_time_in    = latest_time_ff;
      produced_in       = produced_ff;
      consumed_in       = consumed_ff;
      ring_ctrl         = '0;
      rsp_valid_in      = rsp_valid_ff && !rsp_bus.ready;
      ready_res_in      = ready_res_ff;
      from_queue_in     = from_queue_ff;
      out_x_in          = out_x_ff;
      out_y_in          = out_y_ff;
      out_buttons_in    = out_buttons_ff;
      out_time_in       = out_time_ff;
      dropped_in        = dropped_ff;
      if (req_fire) begin
         rsp_valid_in   = 1'b1;
         ready_res_in   = 1'b0;
         from_queue_in  = 1'b0;
         out_x_in       = '0;
         out_y_in       = '0;
         out_buttons_in = '0;
         out_time_in    = '0;
         dropped_in     = 1'b0;
         case (req_bus.mode)
            MODE_REPORT: begin
               latest_x_in       = req_bus.pos_x;
               latest_y_in       = req_bus.pos_y;
               latest_buttons_in = req_bus.buttons;
               latest_time_in    = req_bus.time_ms;
               produced_in       = produced_ff + 1'b1;
               ring_ctrl.push    = button_change && !ring_status.full;
               dropped_in        = button_change && ring_status.full;
            end
            MODE_CONSUME: begin
               if (pending) begin
                  consumed_in  = consumed_ff + 1'b1;
                  ready_res_in = 1'b1;
                  if (!ring_status.empty) begin
                     ring_ctrl.pop  = 1'b1;
                     from_queue_in  = 1'b1;
                     out_x_in       = head.pos_x;
                     out_y_in       = head.pos_y;
                     out_buttons_in = head.buttons;
                     out_time_in    = head.time_ms;
                  end else begin
                     out_x_in       = latest_x_ff;
                     out_y_in       = latest_y_ff;
                     out_buttons_in = latest_buttons_ff;
                     out_time_in    = latest_time_ff;
                  end
               end
            end
            default: begin
               ring_ctrl = '0;
            end
         endcase
      end
   end

   // Control and pointer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         latest_x_ff       <= COORD_RESET;
         latest_y_ff       <= COORD_RESET;
         latest_buttons_ff <= '0;
         latest_time_ff    <= '0;
         produced_ff       <= '0;
         consumed_ff       <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         latest_x_ff       <= latest_x_in;
         latest_y_ff       <= latest_y_in;
         latest_buttons_ff <= latest_buttons_in;
         latest_time_ff    <= latest_time_in;
         produced_ff       <= produced_in;
         consumed_ff       <= consumed_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Response payload registers.
   always_ff @(posedge clock) begin
      ready_res_ff   <= ready_res_in;
      from_queue_ff  <= from_queue_in;
      out_x_ff       <= out_x_in;
      out_y_ff       <= out_y_in;
      out_buttons_ff <= out_buttons_in;
      out_time_ff    <= out_time_in;
      dropped_ff     <= dropped_in;
   end

   pcq_ring u_ring (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ring_ctrl),
      .push_data(push_data),
      .status   (ring_status),
      .head     (head)
   );

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.ready_res     = ready_res_ff;
   assign rsp_bus.from_queue    = from_queue_ff;
   assign rsp_bus.out_x         = out_x_ff;
   assign rsp_bus.out_y         = out_y_ff;
   assign rsp_bus.out_buttons   = out_buttons_ff;
   assign rsp_bus.out_time_ms   = out_time_ff;
   assign rsp_bus.click_dropped = dropped_ff;

`ifndef SYNTHESIS
   // A button change that meets a full ring is reported as dropped.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_bus.mode == MODE_REPORT) && button_change && ring_status.full)
      |=> (rsp_bus.valid && rsp_bus.click_dropped))
      else $error("full-ring button change not flagged as dropped");

   // The ring is never popped while empty.
   assert property (@(posedge clock) disable iff (reset)
      ring_ctrl.pop |-> !ring_status.empty)
      else $error("pop issued on an empty ring");

   // A consume with nothing pending answers not-ready.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_bus.mode == MODE_CONSUME) && !pending)
      |=> (rsp_bus.valid && !rsp_bus.ready_res && !rsp_bus.from_queue))
      else $error("consume with nothing pending returned a report");
`endif

endmodule
